@@ sv/mh2_pkg.sv @@
// Shared types, constants and arithmetic helpers for the MurmurHash2 stream block.
// Used by mh2_front, mh2_queue, mh2_back and murmur2_hash32_stream; depends on nothing.
`default_nettype none

package mh2_pkg;

  // Mixing and finalization constants
  localparam logic [31:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned MixShift  = 24;
  localparam logic [31:0] Seed      = 32'd97;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;
  localparam logic [2:0]  FullBytes = 3'd4;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // What the back end does with one item
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FULL,
    OP_TAIL
  } op_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic [31:0] value;  // mixed key (full word) or masked tail bytes
    logic [31:0] seed;   // seed XOR total length, used on a first item
    op_e         op;
    logic        first;
    logic        last;
  } mh2_op_t;

  // Low 32 bits of a 32x32 product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = a * b;
    return prod[31:0];
  endfunction

  // Mask that keeps the valid low bytes of a tail word
  function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
    logic [31:0] mask;
    unique case (cnt)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

@@ sv/mh2_front.sv @@
// Front end: accepts input items, classifies them and mixes full-word keys
// in two multiply stages. Depends on mh2_pkg; feeds mh2_queue.
`default_nettype none

module mh2_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [31:0]      data_word_i,
  input  wire logic [2:0]       byte_count_i,
  input  wire logic             first_item_i,
  input  wire logic             last_item_i,
  input  wire logic [31:0]      total_length_i,
  output logic                  push_o,
  output mh2_pkg::mh2_op_t      push_op_o,
  input  wire logic             q_full_i
);

  logic             s1_valid_q;
  logic             s2_valid_q;
  mh2_pkg::mh2_op_t s1_op_q;
  mh2_pkg::mh2_op_t s2_op_q;
  mh2_pkg::mh2_op_t in_op;
  mh2_pkg::mh2_op_t s2_next;
  logic             s1_adv;
  logic             s2_adv;
  logic             in_take;

  // Advance each stage when the one ahead has room
  assign s2_adv     = !q_full_i;
  assign s1_adv     = !s2_valid_q || s2_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Classify the item and take the first key multiply
  always_comb begin
    in_op       = '0;
    in_op.seed  = mh2_pkg::Seed ^ total_length_i;
    in_op.first = first_item_i;
    in_op.last  = last_item_i;
    priority if (byte_count_i >= mh2_pkg::FullBytes) begin
      in_op.op    = mh2_pkg::OP_FULL;
      in_op.value = mh2_pkg::mul32(data_word_i, mh2_pkg::MixMul);
    end else if (byte_count_i != 3'd0) begin
      in_op.op    = mh2_pkg::OP_TAIL;
      in_op.value = data_word_i & mh2_pkg::tail_mask(byte_count_i);
    end else begin
      in_op.op    = mh2_pkg::OP_NONE;
      in_op.value = data_word_i;
    end
  end

  // Finish the key mix: fold the top byte down, multiply again
  always_comb begin
    s2_next = s1_op_q;
    if (s1_op_q.op == mh2_pkg::OP_FULL) begin
      s2_next.value = mh2_pkg::mul32(s1_op_q.value ^ (s1_op_q.value >> mh2_pkg::MixShift),
                                     mh2_pkg::MixMul);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv || !s1_valid_q) begin
        s1_valid_q <= in_take;
      end
      if (s2_adv || !s2_valid_q) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q <= in_op;
    end
    if (s1_valid_q && s1_adv) begin
      s2_op_q <= s2_next;
    end
  end

  assign push_o    = s2_valid_q && !q_full_i;
  assign push_op_o = s2_op_q;

`ifndef SYNTHESIS
  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q))
    else $error("stage 2 filled without stage 1 holding an item");
  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && q_full_i) |=> s2_valid_q && $stable(s2_op_q))
    else $error("stage 2 item lost while queue full");
  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && q_full_i)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

@@ sv/mh2_queue.sv @@
// Short register queue between front and back ends.
// Depends on mh2_pkg for the entry type.
`default_nettype none

module mh2_queue #(
  parameter int unsigned Depth = mh2_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mh2_pkg::mh2_op_t push_op_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output mh2_pkg::mh2_op_t      head_op_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mh2_pkg::mh2_op_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign head_op_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("fill count did not follow a push");
`endif

endmodule

`default_nettype wire

@@ sv/mh2_back.sv @@
// Back end: folds classified items into the running hash, finalizes on the
// last item and holds the result in an output register. Depends on mh2_pkg.
`default_nettype none

module mh2_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mh2_pkg::mh2_op_t head_op_i,
  input  wire logic             q_empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [31:0]           hash_value_o
);

  typedef enum logic [1:0] {
    ST_TAKE,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e      state_q;
  logic [31:0] hash_q;
  logic [31:0] fin_q;
  logic [31:0] out_hash_q;
  logic        out_valid_q;
  logic [31:0] base;
  logic [31:0] mul_in;
  logic [31:0] prod;
  logic [31:0] mix_hash;
  logic [31:0] fin_in;
  logic        out_free;

  assign pop_o    = (state_q == ST_TAKE) && !q_empty_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // One shared multiplier serves both full-word and tail updates
  always_comb begin
    base   = head_op_i.first ? head_op_i.seed : hash_q;
    mul_in = (head_op_i.op == mh2_pkg::OP_FULL) ? base : (base ^ head_op_i.value);
    prod   = mh2_pkg::mul32(mul_in, mh2_pkg::MixMul);
    unique case (head_op_i.op)
      mh2_pkg::OP_FULL: mix_hash = prod ^ head_op_i.value;
      mh2_pkg::OP_TAIL: mix_hash = prod;
      default:          mix_hash = base;
    endcase
  end

  assign fin_in = hash_q ^ (hash_q >> mh2_pkg::FinShiftA);

  // Sequencer, running hash and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_TAKE;
      hash_q      <= '0;
      fin_q       <= '0;
      out_hash_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result once taken; the emit step reloads it itself
      if (out_valid_q && !out_stall_i && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_TAKE: begin
          if (!q_empty_i) begin
            hash_q <= mix_hash;
            if (head_op_i.last) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          fin_q   <= mh2_pkg::mul32(fin_in, mh2_pkg::MixMul);
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_hash_q  <= fin_q ^ (fin_q >> mh2_pkg::FinShiftB);
            out_valid_q <= 1'b1;
            state_q     <= ST_TAKE;
          end
        end
        default: state_q <= ST_TAKE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

`ifndef SYNTHESIS
  a_fin_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> state_q == ST_EMIT)
    else $error("finalize step did not move to emit");
  a_emit_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && $past(state_q) != ST_EMIT) |-> $past(state_q) == ST_FIN)
    else $error("emit entered without finalize");
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result raised outside emit");
`endif

endmodule

`default_nettype wire

@@ sv/murmur2_hash32_stream.sv @@
// Top level of the streaming 32-bit MurmurHash2 block (seed 97).
// Instantiates mh2_front, mh2_queue and mh2_back; depends on mh2_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one little-endian word per
//   item with its byte count and first/last marks; total_length_i counts on a
//   first item. Output channel (out_valid_o / out_stall_i) gives one finalized
//   hash per last item.
//   Once accepted, a last item passes through the second key-mix stage, the
//   queue write, the hash update, the finalize multiply and the output load
//   before its hash shows.
//   Throughput: the back end folds one item per cycle; a last item holds it
//   through the update, finalize multiply and output load steps, or longer
//   while the output register is still full. The front end and the queue keep
//   taking items meanwhile, so the input stalls only once the queue is full.
//   Reset clears the running hash to zero and empties the pipeline and queue.
//   When the receiver stalls, the result holds in the output register, the
//   back end waits at its emit step and the queue fills behind it.
`default_nettype none

module murmur2_hash32_stream #(
  parameter int unsigned QueueDepth = mh2_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        first_item_i,
  input  wire logic        last_item_i,
  input  wire logic [31:0] total_length_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_value_o
);

  mh2_pkg::mh2_op_t push_op;
  mh2_pkg::mh2_op_t head_op;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  // Accept and classify
  mh2_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .first_item_i   (first_item_i),
    .last_item_i    (last_item_i),
    .total_length_i (total_length_i),
    .push_o         (push),
    .push_op_o      (push_op),
    .q_full_i       (q_full)
  );

  // Decouple front and back
  mh2_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (q_empty)
  );

  // Fold, finalize and emit
  mh2_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_op_i    (head_op),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

`default_nettype wire
